>>> rtl/isr_pkg.sv
// Package for the Ising ring spin update block.
// Holds the field widths, register indexes, command codes and register reset values.
// No dependencies.
package isr_pkg;

  localparam int unsigned SITE_W = 10;
  localparam int unsigned RAND_W = 16;
  localparam int unsigned TOT_W  = 12;
  localparam int unsigned PROB_W = 48;
  localparam int unsigned SLOT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  // wide enough to hold any ring size
  localparam int unsigned EXT_W  = 17;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [PROB_W-1:0]    prob_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [TOT_W-1:0]     tot_t;

  localparam cfg_idx_t CFG_GIBBS_MODE     = 2'd0;
  localparam cfg_idx_t CFG_FLIP_PROB_UP   = 2'd1;
  localparam cfg_idx_t CFG_FLIP_PROB_DOWN = 2'd2;
  localparam cfg_idx_t CFG_HEAT_BATH_PROB = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  localparam prob_t FLIP_PROB_RST = 48'hFFFF_FFFF_FFFF;
  localparam prob_t HEAT_BATH_RST = 48'h8000_8000_8000;

endpackage

>>> rtl/isr_ram.sv
// Generic synchronous RAM: one write port, NUM_RD read ports with registered data.
// No dependencies.
module isr_ram #(
  parameter int unsigned WIDTH  = 1,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned NUM_RD = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i [NUM_RD],
  output logic [WIDTH-1:0]         rd_data_o [NUM_RD]
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned p = 0; p < NUM_RD; p++) begin
      rd_data_o[p] <= mem_q[rd_addr_i[p]];
    end
  end

endmodule

>>> rtl/ising_ring_spin_update.sv
// Ising ring spin update, top level: spin memories, move decision and running totals.
// Depends on isr_pkg and isr_ram.
//
// A ring of NUM_SPINS spins with periodic neighbours. Each input transaction loads one
// spin or attempts one Metropolis or Gibbs move; each gives one result transaction with
// the new spin, a change flag and the running magnetization and bond sum (low 12 bits).
// A transaction is one registered read of the site and both neighbours from two
// identical spin memories, then the decision and write-back, held while the output
// stalls. After reset a clearing pass sets every spin to +1 with the input stalled;
// configuration writes are taken throughout. A site at or beyond NUM_SPINS leaves the
// state untouched. Energy is -J*bond_sum - h*magnetization, computed outside.
module ising_ring_spin_update #(
  parameter int unsigned NUM_SPINS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  isr_pkg::cfg_idx_t                   cfg_index_i,
  input  isr_pkg::prob_t                      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                in_command_i,
  input  logic [isr_pkg::SITE_W-1:0]          in_site_i,
  input  logic                                in_load_value_i,
  input  logic [isr_pkg::RAND_W-1:0]          in_random_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                out_changed_o,
  output logic                                out_new_spin_o,
  output logic signed [isr_pkg::TOT_W-1:0]    out_magnetization_o,
  output logic signed [isr_pkg::TOT_W-1:0]    out_bond_sum_o
);

  localparam int unsigned AW = $clog2(NUM_SPINS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SPINS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  logic gibbs_mode_q;
  isr_pkg::prob_t flip_up_q, flip_down_q, heat_bath_q;

  logic command_q, load_value_q;
  logic [isr_pkg::SITE_W-1:0] site_q;
  logic [isr_pkg::RAND_W-1:0] random_q;

  isr_pkg::tot_t mag_q, mag_d, bond_q, bond_d;

  logic out_valid_q, out_changed_q, out_new_spin_q;
  isr_pkg::tot_t out_mag_q, out_bond_q;

  logic [isr_pkg::SITE_W-1:0] site_sel;
  logic [isr_pkg::EXT_W-1:0] site_ext;
  logic [AW-1:0] site_addr, left_addr, right_addr;
  logic in_range;

  logic [AW-1:0] nb_raddr [2];
  logic [0:0] nb_rdata [2];
  logic [AW-1:0] own_raddr [1];
  logic [0:0] own_rdata [1];

  logic ram_we, ram_wdata;
  logic [AW-1:0] ram_waddr;

  logic left_bit, right_bit, old_bit, next_bit, changed;
  logic [1:0] nb_idx;
  isr_pkg::prob_t prob_reg;
  isr_pkg::slot_t slot;
  logic exec_fire;

  // Read addresses
  assign site_sel  = (state_q == ST_IDLE) ? in_site_i : site_q;
  assign site_ext  = {{(isr_pkg::EXT_W - isr_pkg::SITE_W){1'b0}}, site_sel};
  assign in_range  = site_ext < isr_pkg::EXT_W'(NUM_SPINS);
  assign site_addr = site_ext[AW-1:0];
  assign left_addr  = (site_addr == '0) ? LAST_ADDR : site_addr - AW'(1);
  assign right_addr = (site_addr == LAST_ADDR) ? '0 : site_addr + AW'(1);

  assign nb_raddr[0]  = left_addr;
  assign nb_raddr[1]  = right_addr;
  assign own_raddr[0] = site_addr;

  isr_ram #(.WIDTH(1), .DEPTH(NUM_SPINS), .NUM_RD(2)) u_nb_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_addr_i (nb_raddr),
    .rd_data_o (nb_rdata)
  );

  isr_ram #(.WIDTH(1), .DEPTH(NUM_SPINS), .NUM_RD(1)) u_own_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_addr_i (own_raddr),
    .rd_data_o (own_rdata)
  );

  // Move decision
  assign left_bit  = nb_rdata[0][0];
  assign right_bit = nb_rdata[1][0];
  assign old_bit   = own_rdata[0][0];
  assign nb_idx    = {1'b0, left_bit} + {1'b0, right_bit};

  always_comb begin
    if (gibbs_mode_q) begin
      prob_reg = heat_bath_q;
    end else if (old_bit) begin
      prob_reg = flip_up_q;
    end else begin
      prob_reg = flip_down_q;
    end
    case (nb_idx)
      2'd0:    slot = prob_reg[15:0];
      2'd1:    slot = prob_reg[31:16];
      2'd2:    slot = prob_reg[47:32];
      default: slot = prob_reg[15:0];
    endcase
    if (command_q == isr_pkg::CMD_LOAD) begin
      next_bit = load_value_q;
    end else if (gibbs_mode_q) begin
      next_bit = random_q < slot;
    end else begin
      next_bit = (random_q <= slot) ? ~old_bit : old_bit;
    end
  end

  assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign changed   = in_range && (next_bit != old_bit);

  // Totals
  always_comb begin
    mag_d  = mag_q;
    bond_d = bond_q;
    if (changed) begin
      mag_d = old_bit ? mag_q - isr_pkg::TOT_W'(2) : mag_q + isr_pkg::TOT_W'(2);
      if (left_bit == right_bit) begin
        bond_d = (old_bit == left_bit) ? bond_q - isr_pkg::TOT_W'(4)
                                       : bond_q + isr_pkg::TOT_W'(4);
      end
    end
  end

  // Memory write and control
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    ram_we    = 1'b0;
    ram_waddr = site_addr;
    ram_wdata = next_bit;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = 1'b1;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          ram_we  = changed;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      gibbs_mode_q <= 1'b0;
      flip_up_q    <= isr_pkg::FLIP_PROB_RST;
      flip_down_q  <= isr_pkg::FLIP_PROB_RST;
      heat_bath_q  <= isr_pkg::HEAT_BATH_RST;
      mag_q        <= isr_pkg::TOT_W'(NUM_SPINS);
      bond_q       <= isr_pkg::TOT_W'(NUM_SPINS);
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          isr_pkg::CFG_GIBBS_MODE:     gibbs_mode_q <= cfg_data_i[0];
          isr_pkg::CFG_FLIP_PROB_UP:   flip_up_q    <= cfg_data_i;
          isr_pkg::CFG_FLIP_PROB_DOWN: flip_down_q  <= cfg_data_i;
          isr_pkg::CFG_HEAT_BATH_PROB: heat_bath_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (exec_fire) begin
        mag_q       <= mag_d;
        bond_q      <= bond_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the transaction and the result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      command_q    <= in_command_i;
      site_q       <= in_site_i;
      load_value_q <= in_load_value_i;
      random_q     <= in_random_value_i;
    end
    if (exec_fire) begin
      out_changed_q  <= changed;
      out_new_spin_q <= in_range & next_bit;
      out_mag_q      <= mag_d;
      out_bond_q     <= bond_d;
    end
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign out_changed_o       = out_changed_q;
  assign out_new_spin_o      = out_new_spin_q;
  assign out_magnetization_o = out_mag_q;
  assign out_bond_sum_o      = out_bond_q;

endmodule
